[rtl/heartbeat_failure_detector_assert.svh]
// Assertion macros for the heartbeat failure detector checker.
`ifndef HEARTBEAT_FAILURE_DETECTOR_ASSERT_SVH
`define HEARTBEAT_FAILURE_DETECTOR_ASSERT_SVH
// Same-cycle implication, sampled on clk and disabled during rst.
`define HBFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled during rst.
`define HBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/hbfd_pkg.sv]
// Shared constants, codes and control types of the heartbeat failure detector.
`timescale 1ns / 1ps
package hbfd_pkg;
  localparam int WINDOW = 16;
  localparam int ENDPOINTS = 64;
  localparam int EP_AW = $clog2(ENDPOINTS);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int TIME_W = 32;
  localparam int SUM_W = TIME_W + CNT_W;
  localparam int META_W = CNT_W + PTR_W + SUM_W;
  localparam int RING_DEPTH = ENDPOINTS * WINDOW;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int PHI_W = 20;
  localparam int PHI_FRAC = 12;
  localparam int NUM_W = TIME_W + CNT_W + PHI_FRAC;
  localparam int CMP_W = SUM_W + PHI_W;
  localparam int DIV_CW = $clog2(PHI_W);
  localparam int THR_W = 16;
  localparam int PROD_W = THR_W + PHI_W;
  localparam logic [PHI_W-1:0] PHI_MAX = '1;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_INTERPRET = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_FORCE = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_ALIVE = 3'd1;
  localparam logic [2:0] ST_CONVICTED = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_PAUSE = 3'd4;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_PHI_THRESHOLD = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PHI_SCALE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INITIAL_INTERVAL = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_INTERVAL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MIN_INTERVAL = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_PAUSE = 3'd5;

  localparam logic [THR_W-1:0] RST_PHI_THRESHOLD = 16'd32768;
  localparam logic [THR_W-1:0] RST_PHI_SCALE = 16'd1779;
  localparam logic [TIME_W-1:0] RST_INITIAL_INTERVAL = 32'd2000;
  localparam logic [TIME_W-1:0] RST_MAX_INTERVAL = 32'd2000;
  localparam logic [TIME_W-1:0] RST_MIN_INTERVAL = 32'd1000;
  localparam logic [TIME_W-1:0] RST_MAX_PAUSE = 32'd5000;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_READ = 10'b0000000010,
    S_PUSH = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_SAT  = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_PROD = 10'b0001000000,
    S_CONV = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic push;
    logic mul;
    logic sat;
    logic div;
    logic prod;
    logic conv;
    logic emit;
  } hbfd_cmd_t;

  typedef struct packed {
    logic go_push;
    logic go_phi;
    logic sat_hit;
    logic div_last;
    logic out_full;
  } hbfd_sts_t;
endpackage

[rtl/hbfd_if.sv]
// Request and result channel interfaces of the heartbeat failure detector.
`timescale 1ns / 1ps
interface hbfd_req_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [5:0] endpoint_id;
  logic [31:0] now_time;
  modport source (output valid, cmd, endpoint_id, now_time, input ready);
  modport sink (input valid, cmd, endpoint_id, now_time, output ready);
endinterface

interface hbfd_res_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [5:0] endpoint_out;
  logic [19:0] phi_value;
  modport source (output valid, status, endpoint_out, phi_value, input ready);
  modport sink (input valid, status, endpoint_out, phi_value, output ready);
endinterface

[rtl/hbfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hbfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/hbfd_ctrl.sv]
// Sequencer state machine of the heartbeat failure detector.
`timescale 1ns / 1ps
module hbfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hbfd_pkg::hbfd_sts_t sts,
  output hbfd_pkg::hbfd_cmd_t cmd
);
  hbfd_pkg::state_t state, state_next;

  assign req_ready = (state == hbfd_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      hbfd_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = hbfd_pkg::S_READ;
        end
      end
      hbfd_pkg::S_READ: begin
        cmd.decide = 1'b1;
        if (sts.go_push) begin
          state_next = hbfd_pkg::S_PUSH;
        end else if (sts.go_phi) begin
          state_next = hbfd_pkg::S_MUL;
        end else begin
          state_next = hbfd_pkg::S_OUT;
        end
      end
      hbfd_pkg::S_PUSH: begin
        cmd.push = 1'b1;
        state_next = hbfd_pkg::S_OUT;
      end
      hbfd_pkg::S_MUL: begin
        cmd.mul = 1'b1;
        state_next = hbfd_pkg::S_SAT;
      end
      hbfd_pkg::S_SAT: begin
        cmd.sat = 1'b1;
        state_next = sts.sat_hit ? hbfd_pkg::S_PROD : hbfd_pkg::S_DIV;
      end
      hbfd_pkg::S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_next = hbfd_pkg::S_PROD;
        end
      end
      hbfd_pkg::S_PROD: begin
        cmd.prod = 1'b1;
        state_next = hbfd_pkg::S_CONV;
      end
      hbfd_pkg::S_CONV: begin
        cmd.conv = 1'b1;
        state_next = hbfd_pkg::S_OUT;
      end
      hbfd_pkg::S_OUT: begin
        if (!sts.out_full) begin
          cmd.emit = 1'b1;
          state_next = hbfd_pkg::S_IDLE;
        end else begin
          state_next = hbfd_pkg::S_WAIT;
        end
      end
      hbfd_pkg::S_WAIT: begin
        if (!sts.out_full) begin
          cmd.emit = 1'b1;
          state_next = hbfd_pkg::S_IDLE;
        end
      end
      default: state_next = hbfd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbfd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/hbfd_dp.sv]
// Datapath: heartbeat table, window update, phi divider and result register.
`timescale 1ns / 1ps
module hbfd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  hbfd_pkg::hbfd_cmd_t               cmd,
  output hbfd_pkg::hbfd_sts_t               sts,
  input  logic [1:0]                        req_cmd,
  input  logic [5:0]                        req_endpoint_id,
  input  logic [31:0]                       req_now_time,
  input  logic                              cfg_we,
  input  logic [hbfd_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [31:0]                       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [5:0]                        out_endpoint,
  output logic [19:0]                       out_phi
);
  localparam int AW = hbfd_pkg::EP_AW;
  localparam int PW = hbfd_pkg::PTR_W;
  localparam int CW = hbfd_pkg::CNT_W;
  localparam int SW = hbfd_pkg::SUM_W;
  localparam int TW = hbfd_pkg::TIME_W;
  localparam int FW = hbfd_pkg::PHI_W;

  logic [hbfd_pkg::THR_W-1:0] phi_threshold, phi_scale;
  logic [TW-1:0] initial_interval, max_interval, min_interval, max_pause;
  logic [TW-1:0] last_interpret_time, last_pause_time;
  logic interpret_seen, pause_seen;
  logic [hbfd_pkg::ENDPOINTS-1:0] entry_valid;

  logic [1:0] cmd_r;
  logic [5:0] ep_r;
  logic [AW-1:0] slot_r;
  logic in_range_r;
  logic [TW-1:0] now_r, gap_r;

  logic [2:0] res_status;
  logic [FW-1:0] res_phi;

  logic la_we, meta_we, ring_we;
  logic [AW-1:0] meta_raddr;
  logic [TW-1:0] la_wdata, la_rdata;
  logic [hbfd_pkg::META_W-1:0] meta_wdata, meta_rdata;
  logic [hbfd_pkg::RING_AW-1:0] ring_waddr, ring_raddr;
  logic [TW-1:0] ring_wdata, ring_rdata;

  logic [CW-1:0] m_cnt;
  logic [PW-1:0] m_ptr, ptr_inc;
  logic [SW-1:0] m_sum;
  logic [TW-1:0] gap, elapsed, diff;
  logic gap_ok, pause_new, pause_hold;

  logic [hbfd_pkg::NUM_W-1:0] num_r;
  logic [SW-1:0] rem;
  logic [SW:0] trial;
  logic [FW-1:0] num_lo, quo;
  logic [hbfd_pkg::DIV_CW-1:0] div_cnt;
  logic [hbfd_pkg::PROD_W-1:0] prod_r;

  function automatic logic [hbfd_pkg::RING_AW-1:0] ring_addr(logic [AW-1:0] s,
                                                             logic [PW-1:0] p);
    ring_addr = hbfd_pkg::RING_AW'(s) * hbfd_pkg::RING_AW'(hbfd_pkg::WINDOW)
              + hbfd_pkg::RING_AW'(p);
  endfunction

  hbfd_ram #(.WIDTH(TW), .DEPTH(hbfd_pkg::ENDPOINTS)) u_last_arrival (
    .clk(clk), .we(la_we), .waddr(slot_r), .wdata(la_wdata),
    .raddr(meta_raddr), .rdata(la_rdata)
  );
  hbfd_ram #(.WIDTH(hbfd_pkg::META_W), .DEPTH(hbfd_pkg::ENDPOINTS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(slot_r), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );
  hbfd_ram #(.WIDTH(TW), .DEPTH(hbfd_pkg::RING_DEPTH)) u_gap_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  assign meta_raddr = cmd.load ? AW'(req_endpoint_id) : slot_r;
  assign {m_cnt, m_ptr, m_sum} = meta_rdata;
  assign ptr_inc = (m_ptr == PW'(hbfd_pkg::WINDOW - 1)) ? '0 : m_ptr + 1'b1;
  assign ring_raddr = ring_addr(slot_r, m_ptr);
  assign gap = now_r - la_rdata;
  assign elapsed = now_r - la_rdata;
  assign gap_ok = (gap <= max_interval) && (gap >= min_interval);
  assign diff = interpret_seen ? now_r - last_interpret_time : '0;
  assign pause_new = diff > max_pause;
  assign pause_hold = pause_seen && ((now_r - last_pause_time) < max_pause);

  assign sts.go_push = in_range_r && (cmd_r == hbfd_pkg::CMD_REPORT)
                     && entry_valid[slot_r] && gap_ok;
  assign sts.go_phi = in_range_r && (cmd_r == hbfd_pkg::CMD_INTERPRET)
                    && entry_valid[slot_r] && !pause_new && !pause_hold;
  assign sts.sat_hit = hbfd_pkg::CMP_W'(num_r) >= {m_sum, {FW{1'b0}}};
  assign sts.div_last = (div_cnt == hbfd_pkg::DIV_CW'(FW - 1));
  assign sts.out_full = out_valid && !out_ready;

  assign trial = {rem, num_lo[FW-1]};

  always_comb begin
    la_we = 1'b0;
    meta_we = 1'b0;
    ring_we = 1'b0;
    la_wdata = now_r;
    meta_wdata = '0;
    ring_waddr = ring_addr(slot_r, m_ptr);
    ring_wdata = gap_r;
    if (cmd.decide && in_range_r && (cmd_r == hbfd_pkg::CMD_REPORT)) begin
      la_we = !(entry_valid[slot_r] && gap_ok);
      if (!entry_valid[slot_r]) begin
        meta_we = 1'b1;
        ring_we = 1'b1;
        meta_wdata = {CW'(1),
                      (hbfd_pkg::WINDOW == 1) ? PW'(0) : PW'(1),
                      SW'(initial_interval)};
        ring_waddr = ring_addr(slot_r, '0);
        ring_wdata = initial_interval;
      end
    end else if (cmd.push) begin
      la_we = 1'b1;
      meta_we = 1'b1;
      ring_we = 1'b1;
      if (m_cnt >= CW'(hbfd_pkg::WINDOW)) begin
        meta_wdata = {m_cnt, ptr_inc, m_sum - SW'(ring_rdata) + SW'(gap_r)};
      end else begin
        meta_wdata = {m_cnt + 1'b1, ptr_inc, m_sum + SW'(gap_r)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_threshold <= hbfd_pkg::RST_PHI_THRESHOLD;
      phi_scale <= hbfd_pkg::RST_PHI_SCALE;
      initial_interval <= hbfd_pkg::RST_INITIAL_INTERVAL;
      max_interval <= hbfd_pkg::RST_MAX_INTERVAL;
      min_interval <= hbfd_pkg::RST_MIN_INTERVAL;
      max_pause <= hbfd_pkg::RST_MAX_PAUSE;
    end else if (cfg_we) begin
      case (cfg_index)
        hbfd_pkg::REG_PHI_THRESHOLD: phi_threshold <= cfg_data[hbfd_pkg::THR_W-1:0];
        hbfd_pkg::REG_PHI_SCALE: phi_scale <= cfg_data[hbfd_pkg::THR_W-1:0];
        hbfd_pkg::REG_INITIAL_INTERVAL: initial_interval <= cfg_data;
        hbfd_pkg::REG_MAX_INTERVAL: max_interval <= cfg_data;
        hbfd_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data;
        hbfd_pkg::REG_MAX_PAUSE: max_pause <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      interpret_seen <= 1'b0;
      pause_seen <= 1'b0;
      last_interpret_time <= '0;
      last_pause_time <= '0;
    end else if (cmd.decide && in_range_r) begin
      case (cmd_r)
        hbfd_pkg::CMD_REPORT: entry_valid[slot_r] <= 1'b1;
        hbfd_pkg::CMD_INTERPRET: begin
          if (entry_valid[slot_r]) begin
            last_interpret_time <= now_r;
            interpret_seen <= 1'b1;
            if (pause_new) begin
              last_pause_time <= now_r;
              pause_seen <= 1'b1;
            end
          end
        end
        hbfd_pkg::CMD_REMOVE: entry_valid[slot_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= req_cmd;
      ep_r <= req_endpoint_id;
      slot_r <= AW'(req_endpoint_id);
      in_range_r <= (32'(req_endpoint_id) < hbfd_pkg::ENDPOINTS);
      now_r <= req_now_time;
    end
    if (cmd.decide) begin
      gap_r <= gap;
      if (!in_range_r) begin
        res_status <= hbfd_pkg::ST_UNKNOWN;
        res_phi <= '0;
      end else if ((cmd_r == hbfd_pkg::CMD_INTERPRET) && !entry_valid[slot_r]) begin
        res_status <= hbfd_pkg::ST_UNKNOWN;
        res_phi <= '0;
      end else if ((cmd_r == hbfd_pkg::CMD_INTERPRET) && (pause_new || pause_hold)) begin
        res_status <= hbfd_pkg::ST_PAUSE;
        res_phi <= '0;
      end else if (cmd_r == hbfd_pkg::CMD_FORCE) begin
        res_status <= hbfd_pkg::ST_CONVICTED;
        res_phi <= FW'(phi_threshold);
      end else begin
        res_status <= hbfd_pkg::ST_DONE;
        res_phi <= '0;
      end
    end
    if (cmd.mul) begin
      num_r <= {(hbfd_pkg::TIME_W + hbfd_pkg::CNT_W)'(elapsed) * m_cnt,
                {hbfd_pkg::PHI_FRAC{1'b0}}};
    end
    if (cmd.sat) begin
      if (sts.sat_hit) begin
        res_phi <= (num_r == '0) ? '0 : hbfd_pkg::PHI_MAX;
      end
      rem <= SW'(num_r >> FW);
      num_lo <= num_r[FW-1:0];
      div_cnt <= '0;
    end
    if (cmd.div) begin
      if (trial >= {1'b0, m_sum}) begin
        rem <= SW'(trial - {1'b0, m_sum});
        quo <= {quo[FW-2:0], 1'b1};
        if (sts.div_last) res_phi <= {quo[FW-2:0], 1'b1};
      end else begin
        rem <= trial[SW-1:0];
        quo <= {quo[FW-2:0], 1'b0};
        if (sts.div_last) res_phi <= {quo[FW-2:0], 1'b0};
      end
      num_lo <= {num_lo[FW-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.prod) begin
      prod_r <= phi_scale * res_phi;
    end
    if (cmd.conv) begin
      res_status <= (prod_r > hbfd_pkg::PROD_W'({phi_threshold,
                                                {hbfd_pkg::PHI_FRAC{1'b0}}}))
                  ? hbfd_pkg::ST_CONVICTED : hbfd_pkg::ST_ALIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_endpoint <= ep_r;
      out_phi <= res_phi;
    end
  end
endmodule

[rtl/heartbeat_failure_detector.sv]
// Top level of the heartbeat failure detector.
// A request on req_in carries a command (report, interpret, remove, force),
// an endpoint slot and the current time. Each request gives exactly one
// result on res_out: a status, the endpoint slot and a Q8.12 phi value.
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce
// this. The block handles one request at a time; req_in.ready is high only
// while the sequencer is idle. Remove, force, unknown endpoints, plain reports
// and pause-suppressed interprets go from the read step straight to the
// output; a report that enters the gap window passes a push step first. An
// interpret forms phi in multiply, saturate, divide, product and convert
// steps, skipping the divide when phi saturates; the restoring divider forms
// phi one quotient bit per cycle. The next request can be taken in the cycle
// after the result is written. Results sit in an output register, so the
// next request is taken while a result still waits; if the receiver stalls
// with a result still held, the sequencer waits before writing the next one.
// Reset clears the slot valid bits, the pause tracking and the registers to
// their defaults; the per-slot memories need no clearing.
`timescale 1ns / 1ps
module heartbeat_failure_detector (
  input  logic                        clk,
  input  logic                        rst,
  hbfd_req_if.sink                    req_in,
  hbfd_res_if.source                  res_out,
  input  logic                        cfg_we,
  input  logic [hbfd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  hbfd_pkg::hbfd_cmd_t cmd;
  hbfd_pkg::hbfd_sts_t sts;

  hbfd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_in.valid), .req_ready(req_in.ready),
    .sts(sts), .cmd(cmd)
  );

  hbfd_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_cmd(req_in.cmd), .req_endpoint_id(req_in.endpoint_id),
    .req_now_time(req_in.now_time),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .out_status(res_out.status), .out_endpoint(res_out.endpoint_out),
    .out_phi(res_out.phi_value)
  );
endmodule

[rtl/hbfd_checker.sv]
// Port-level assertion checker of the heartbeat failure detector, with its bind.
`timescale 1ns / 1ps
`include "heartbeat_failure_detector_assert.svh"
module hbfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [19:0] out_phi
);
  logic zero_phi_status;

  assign zero_phi_status = out_status inside {hbfd_pkg::ST_DONE, hbfd_pkg::ST_UNKNOWN,
                                              hbfd_pkg::ST_PAUSE};

  `HBFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `HBFD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken")
  `HBFD_ASSERT_NOW(a_status_range, out_valid, out_status <= hbfd_pkg::ST_PAUSE, "bad status")
  `HBFD_ASSERT_NOW(a_phi_zero, out_valid && zero_phi_status, out_phi == '0, "phi not zero")
endmodule

bind heartbeat_failure_detector hbfd_checker u_hbfd_checker (
  .clk(clk), .rst(rst),
  .in_valid(req_in.valid), .in_ready(req_in.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .out_status(res_out.status), .out_phi(res_out.phi_value)
);

[verif/hbfd_test_pkg.sv]
// Shared request and result item types for the heartbeat failure detector testbench.
`timescale 1ns / 1ps
package hbfd_test_pkg;
  typedef struct {
    logic [1:0] cmd;
    logic [5:0] endpoint_id;
    logic [31:0] now_time;
  } hb_req_t;

  typedef struct {
    logic [2:0] status;
    logic [5:0] endpoint_out;
    logic [19:0] phi_value;
  } hb_res_t;
endpackage

[verif/hbfd_test_if.sv]
// Configuration write channel used by the heartbeat failure detector testbench.
`timescale 1ns / 1ps
interface hbfd_cfg_if;
  logic we;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output we, index, data);
  modport sink (input we, index, data);
endinterface

[verif/heartbeat_failure_detector_test.sv]
// Self-checking testbench of the heartbeat failure detector with a built-in predictor.
`timescale 1ns / 1ps
module heartbeat_failure_detector_test;
  logic clk = 1'b0;
  logic rst = 1'b1;

  hbfd_req_if req ();
  hbfd_res_if res ();
  hbfd_cfg_if cfg ();

  heartbeat_failure_detector dut (
    .clk(clk), .rst(rst), .req_in(req.sink), .res_out(res.source),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] thr, fac;
  logic [31:0] init_iv, max_iv, min_iv, max_ps;
  logic ep_valid [hbfd_pkg::ENDPOINTS];
  logic [31:0] last_hb [hbfd_pkg::ENDPOINTS];
  logic [31:0] ring [hbfd_pkg::ENDPOINTS][hbfd_pkg::WINDOW];
  int unsigned cnt [hbfd_pkg::ENDPOINTS];
  int unsigned ptr [hbfd_pkg::ENDPOINTS];
  logic [63:0] sum [hbfd_pkg::ENDPOINTS];
  logic [31:0] last_interp, last_pause;
  logic interp_seen, pause_seen;

  hbfd_test_pkg::hb_req_t pending_reqs[$];
  hbfd_test_pkg::hb_res_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_convicted = 0;
  int n_paused = 0;
  int send_idle_pct = 10;
  int recv_stall_pct = 54;
  logic req_accepted = 1'b0;

  task automatic push_gap(int e, logic [31:0] g);
    if (cnt[e] >= hbfd_pkg::WINDOW) sum[e] -= ring[e][ptr[e]];
    else cnt[e]++;
    ring[e][ptr[e]] = g;
    sum[e] += g;
    ptr[e] = (ptr[e] + 1) % hbfd_pkg::WINDOW;
  endtask

  function automatic logic [19:0] phi_of(int e, logic [31:0] now);
    logic [63:0] el, q;
    el = {32'd0, now - last_hb[e]};
    if (sum[e] == 0) return (el == 0) ? 20'd0 : 20'hFFFFF;
    q = ((el * cnt[e]) << 12) / sum[e];
    return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  task automatic predict_detector(hbfd_test_pkg::hb_req_t r);
    hbfd_test_pkg::hb_res_t o;
    logic [31:0] diff;
    int e;
    e = int'(r.endpoint_id);
    o.status = hbfd_pkg::ST_DONE;
    o.endpoint_out = r.endpoint_id;
    o.phi_value = '0;
    case (r.cmd)
      hbfd_pkg::CMD_REPORT: begin
        if (!ep_valid[e]) begin
          ep_valid[e] = 1'b1;
          cnt[e] = 0;
          ptr[e] = 0;
          sum[e] = 0;
          push_gap(e, init_iv);
        end else begin
          diff = r.now_time - last_hb[e];
          if (diff <= max_iv && diff >= min_iv) push_gap(e, diff);
        end
        last_hb[e] = r.now_time;
      end
      hbfd_pkg::CMD_INTERPRET: begin
        if (!ep_valid[e]) o.status = hbfd_pkg::ST_UNKNOWN;
        else begin
          diff = interp_seen ? r.now_time - last_interp : 32'd0;
          last_interp = r.now_time;
          interp_seen = 1'b1;
          if (diff > max_ps) begin
            last_pause = r.now_time;
            pause_seen = 1'b1;
            o.status = hbfd_pkg::ST_PAUSE;
          end else if (pause_seen && (r.now_time - last_pause) < max_ps) begin
            o.status = hbfd_pkg::ST_PAUSE;
          end else begin
            o.phi_value = phi_of(e, r.now_time);
            o.status = ({48'd0, fac} * o.phi_value > ({48'd0, thr} << 12)) ?
                       hbfd_pkg::ST_CONVICTED : hbfd_pkg::ST_ALIVE;
          end
        end
      end
      hbfd_pkg::CMD_REMOVE: ep_valid[e] = 1'b0;
      hbfd_pkg::CMD_FORCE: begin
        o.status = hbfd_pkg::ST_CONVICTED;
        o.phi_value = {4'd0, thr};
      end
      default: ;
    endcase
    expected_results = {expected_results, o};
  endtask

  // Request driver.
  initial begin
    req.valid = 1'b0;
    req.cmd = '0;
    req.endpoint_id = '0;
    req.now_time = '0;
    cfg.we = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      predict_detector('{req.cmd, req.endpoint_id, req.now_time});
      void'(pending_reqs.pop_front());
      req_accepted = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!(req.valid && !req_accepted)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req.valid <= 1'b1;
          req.cmd <= pending_reqs[0].cmd;
          req.endpoint_id <= pending_reqs[0].endpoint_id;
          req.now_time <= pending_reqs[0].now_time;
        end else begin
          req.valid <= 1'b0;
        end
      end
      req_accepted = 1'b0;
    end
  end

  // Result monitor: sampled at the rising edge, ready changed at the falling edge.
  initial res.ready = 1'b0;
  always @(negedge clk) res.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    hbfd_test_pkg::hb_res_t x;
    if (!rst && res.valid && res.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", res.status);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (res.status == hbfd_pkg::ST_CONVICTED) n_convicted++;
        if (res.status == hbfd_pkg::ST_PAUSE) n_paused++;
        if (res.status !== x.status) begin
          $error("status: expected %0d, got %0d", x.status, res.status);
          errors++;
        end
        if (res.endpoint_out !== x.endpoint_out) begin
          $error("endpoint_out: expected %0d, got %0d", x.endpoint_out, res.endpoint_out);
          errors++;
        end
        if (res.phi_value !== x.phi_value) begin
          $error("phi_value: expected %0d, got %0d", x.phi_value, res.phi_value);
          errors++;
        end
      end
    end
  end

  task automatic add_req(logic [1:0] c, logic [5:0] e, logic [31:0] t);
    hbfd_test_pkg::hb_req_t item;
    item = '{c, e, t};
    pending_reqs = {pending_reqs, item};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [hbfd_pkg::CFG_IW-1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg.we <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    case (idx)
      hbfd_pkg::REG_PHI_THRESHOLD: thr = v[15:0];
      hbfd_pkg::REG_PHI_SCALE: fac = v[15:0];
      hbfd_pkg::REG_INITIAL_INTERVAL: init_iv = v;
      hbfd_pkg::REG_MAX_INTERVAL: max_iv = v;
      hbfd_pkg::REG_MIN_INTERVAL: min_iv = v;
      hbfd_pkg::REG_MAX_PAUSE: max_ps = v;
      default: ;
    endcase
    @(negedge clk);
    cfg.we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] t, logic [15:0] f, logic [31:0] iv,
                         logic [31:0] mx, logic [31:0] mn, logic [31:0] ps);
    write_reg(hbfd_pkg::REG_PHI_THRESHOLD, {16'd0, t});
    write_reg(hbfd_pkg::REG_PHI_SCALE, {16'd0, f});
    write_reg(hbfd_pkg::REG_INITIAL_INTERVAL, iv);
    write_reg(hbfd_pkg::REG_MAX_INTERVAL, mx);
    write_reg(hbfd_pkg::REG_MIN_INTERVAL, mn);
    write_reg(hbfd_pkg::REG_MAX_PAUSE, ps);
  endtask

  // Well-formed heartbeat traffic on a few slots with occasional noise.
  task automatic random_phase(int n, int unsigned step_max, int unsigned jitter);
    logic [31:0] clock_ms;
    logic [1:0] c;
    int k;
    clock_ms = $urandom;
    for (k = 0; k < n; k++) begin
      clock_ms += $urandom_range(step_max) +
                  (($urandom_range(19) == 0) ? $urandom_range(jitter) : 0);
      case ($urandom_range(19)) inside
        [0:8]: c = hbfd_pkg::CMD_REPORT;
        [9:15]: c = hbfd_pkg::CMD_INTERPRET;
        [16:17]: c = hbfd_pkg::CMD_REMOVE;
        default: c = hbfd_pkg::CMD_FORCE;
      endcase
      if ($urandom_range(29) == 0) add_req(c, 6'($urandom), $urandom);
      else add_req(c, 6'(($urandom_range(3) == 0) ? $urandom : $urandom_range(7)), clock_ms);
    end
  endtask

  initial begin
    int e;
    thr = hbfd_pkg::RST_PHI_THRESHOLD;
    fac = hbfd_pkg::RST_PHI_SCALE;
    init_iv = hbfd_pkg::RST_INITIAL_INTERVAL;
    max_iv = hbfd_pkg::RST_MAX_INTERVAL;
    min_iv = hbfd_pkg::RST_MIN_INTERVAL;
    max_ps = hbfd_pkg::RST_MAX_PAUSE;
    for (e = 0; e < hbfd_pkg::ENDPOINTS; e++) ep_valid[e] = 1'b0;
    last_interp = '0;
    last_pause = '0;
    interp_seen = 1'b0;
    pause_seen = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: unknown slots, first interpret, zero elapsed, pauses, force, extremes.
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'hFFFF_FFFF);
    add_req(hbfd_pkg::CMD_REMOVE, 6'd5, 32'd0);
    add_req(hbfd_pkg::CMD_FORCE, 6'd0, 32'd0);
    add_req(hbfd_pkg::CMD_REPORT, 6'd63, 32'hFFFF_FFF0);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'hFFFF_FFF0);
    add_req(hbfd_pkg::CMD_REPORT, 6'd63, 32'd1500);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd3000);
    add_req(hbfd_pkg::CMD_REPORT, 6'd63, 32'd3000);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd9000);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd12000);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd14500);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd17000);
    add_req(hbfd_pkg::CMD_REMOVE, 6'd63, 32'd17000);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd63, 32'd17000);
    add_req(hbfd_pkg::CMD_FORCE, 6'd42, 32'hAAAA_5555);
    drain();
    // Register extremes: all zero, then mostly all ones, each on one slot with reports, interprets and a force.
    set_all(16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    add_req(hbfd_pkg::CMD_REPORT, 6'd1, 32'd100);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd1, 32'd100);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd1, 32'd101);
    add_req(hbfd_pkg::CMD_REPORT, 6'd1, 32'd101);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd1, 32'd101);
    add_req(hbfd_pkg::CMD_FORCE, 6'd1, 32'd0);
    drain();
    set_all(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    add_req(hbfd_pkg::CMD_REPORT, 6'd2, 32'd0);
    add_req(hbfd_pkg::CMD_REPORT, 6'd2, 32'hFFFF_FFFF);
    add_req(hbfd_pkg::CMD_INTERPRET, 6'd2, 32'h7FFF_FFFF);
    add_req(hbfd_pkg::CMD_FORCE, 6'd2, 32'd0);
    drain();

    set_all(hbfd_pkg::RST_PHI_THRESHOLD, hbfd_pkg::RST_PHI_SCALE,
            hbfd_pkg::RST_INITIAL_INTERVAL, hbfd_pkg::RST_MAX_INTERVAL,
            hbfd_pkg::RST_MIN_INTERVAL, hbfd_pkg::RST_MAX_PAUSE);
    random_phase(650, 2400, 9000);
    drain();
    send_idle_pct = 54;
    recv_stall_pct = 10;
    set_all(16'($urandom_range(16'h1FFF)), 16'($urandom_range(16'h3FFF)),
            $urandom_range(400), 500, 50, 1200);
    random_phase(650, 600, 3000);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_all(16'($urandom), 16'($urandom), $urandom_range(100), 32'hFFFF_FFFF, 32'd0,
            32'd100000);
    random_phase(600, 150, 200000);
    drain();

    $display("Checked %0d results from directed corner cases and three random phases",
             n_results);
    $display("with varied registers and stall patterns: %0d convicted, %0d paused.",
             n_convicted, n_paused);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[heartbeat_failure_detector.f]
+incdir+rtl
rtl/hbfd_pkg.sv
rtl/hbfd_if.sv
rtl/hbfd_ram.sv
rtl/hbfd_ctrl.sv
rtl/hbfd_dp.sv
rtl/heartbeat_failure_detector.sv
rtl/hbfd_checker.sv
verif/hbfd_test_pkg.sv
verif/hbfd_test_if.sv
verif/heartbeat_failure_detector_test.sv
